/* hdl/rrla_pkg.sv */
// Shared constants for the round-robin lock arbiter.
// Used by rrla_pick and round_robin_lock_arbiter_top; depends on nothing else.
package rrla_pkg;

  // Request vector width on the input side.
  localparam int REQ_W           = 30;
  // Width of the reported grant index.
  localparam int GRANT_W         = 5;
  // Default line count.
  localparam int NUM_LINES_DEF   = 30;

  // Stream widths, padded to whole bytes.
  localparam int S_TDATA_W       = 32;
  localparam int M_TDATA_W       = 8;

  // Result beat layout, lowest bit first.
  localparam int M_GRANT_VALID_B = 0;
  localparam int M_GRANT_IDX_LO  = 1;
  localparam int M_CHANGED_B     = M_GRANT_IDX_LO + GRANT_W;

endpackage

/* hdl/rrla_pick.sv */
// Rotating-priority search: first active line at or after the pointer, wrapping.
// Depends on rrla_pkg.
module rrla_pick #(
  parameter int NUM_LINES = rrla_pkg::NUM_LINES_DEF,
  parameter int IDX_W     = $clog2(NUM_LINES)
) (
  input  logic [rrla_pkg::REQ_W-1:0] reqs,
  input  logic [IDX_W-1:0]           ptr,
  output logic                       found,
  output logic [IDX_W-1:0]           idx
);
  import rrla_pkg::*;

  logic [REQ_W-1:0] upper;
  logic [IDX_W-1:0] idx_upper;
  logic [IDX_W-1:0] idx_any;

  // Lines at or above the pointer take priority; otherwise the search wraps
  // to the lowest active line.
  always_comb begin
    for (int i = 0; i < REQ_W; i++) begin
      upper[i] = reqs[i] && (i >= int'(ptr));
    end
  end

  always_comb begin
    idx_upper = '0;
    idx_any   = '0;
    for (int i = REQ_W - 1; i >= 0; i--) begin
      if (upper[i]) begin
        idx_upper = IDX_W'(i);
      end
      if (reqs[i]) begin
        idx_any = IDX_W'(i);
      end
    end
  end

  assign found = |reqs;
  assign idx   = (|upper) ? idx_upper : idx_any;

endmodule

/* hdl/round_robin_lock_arbiter_top.sv */
// Round-robin arbiter with grant lock, stream in and stream out.
// Depends on rrla_pkg and rrla_pick.
//
//   channel  dir  beat contents (lowest bit first)
//   s_*      in   tdata: requests[29:0], zero pad; tuser: clear
//   m_*      out  tdata: grant_valid, grant_index[4:0], changed, zero pad
//
// One beat in gives one beat out. A beat is captured in the input register; when the
// result register can take it, the lock check and rotating search update the arbiter
// state and load the result register. A new beat can be taken every cycle as long as
// the result is not stalled.
// Reset clears holder, pointer and both valid flags. While a result is stalled, the
// input register takes at most one more beat and then holds s_tready low.
module round_robin_lock_arbiter_top #(
  parameter int NUM_LINES = rrla_pkg::NUM_LINES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [rrla_pkg::S_TDATA_W-1:0] s_tdata,  // requests[29:0], pad
  input  logic                           s_tuser,  // clear
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [rrla_pkg::M_TDATA_W-1:0] m_tdata   // grant_valid, grant_index[4:0],
                                                   // changed, pad
);
  import rrla_pkg::*;

  localparam int IDX_W = $clog2(NUM_LINES);

  // Input register.
  logic             in_valid;
  logic [REQ_W-1:0] in_reqs;
  logic             in_clear;

  // Arbiter state.
  logic             holder_valid;
  logic [IDX_W-1:0] holder_index;
  logic [IDX_W-1:0] search_pointer;

  logic             holder_valid_next;
  logic [IDX_W-1:0] holder_index_next;
  logic [IDX_W-1:0] search_pointer_next;
  logic             changed_next;

  logic             out_ready;
  logic             advance;

  logic [REQ_W-1:0] line_mask;
  logic [REQ_W-1:0] reqs_eff;
  logic             hv0;
  logic [IDX_W-1:0] ptr0;
  logic             release_hit;
  logic [IDX_W-1:0] ptr1;
  logic             pick_found;
  logic [IDX_W-1:0] pick_idx;

  logic [M_TDATA_W-1:0] result_beat;

  assign out_ready = !m_tvalid || m_tready;
  assign advance   = in_valid && out_ready;
  assign s_tready  = !in_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_reqs  <= s_tdata[REQ_W-1:0];
      in_clear <= s_tuser;
    end
  end

  always_comb begin
    for (int i = 0; i < REQ_W; i++) begin
      line_mask[i] = (i < NUM_LINES);
    end
  end

  // A clear wipes the holder and pointer and hides every request this beat.
  assign reqs_eff = in_clear ? '0 : (in_reqs & line_mask);
  assign hv0      = in_clear ? 1'b0 : holder_valid;
  assign ptr0     = in_clear ? '0 : search_pointer;

  // The holder keeps the grant until its own request drops.
  assign release_hit = hv0 && !reqs_eff[holder_index];
  assign ptr1 = !release_hit ? ptr0 :
                (ptr0 == IDX_W'(NUM_LINES - 1)) ? '0 : ptr0 + 1'b1;

  rrla_pick #(
    .NUM_LINES(NUM_LINES),
    .IDX_W    (IDX_W)
  ) u_pick (
    .reqs (reqs_eff),
    .ptr  (ptr1),
    .found(pick_found),
    .idx  (pick_idx)
  );

  always_comb begin
    holder_valid_next   = hv0 && !release_hit;
    holder_index_next   = holder_index;
    search_pointer_next = ptr1;
    changed_next        = in_clear || release_hit;
    if (!holder_valid_next) begin
      holder_index_next = '0;
      if (pick_found) begin
        holder_valid_next   = 1'b1;
        holder_index_next   = pick_idx;
        search_pointer_next = pick_idx;
        changed_next        = 1'b1;
      end
    end
  end

  always_comb begin
    result_beat                            = '0;
    result_beat[M_GRANT_VALID_B]           = holder_valid_next;
    result_beat[M_GRANT_IDX_LO +: GRANT_W] = holder_valid_next ?
                                             GRANT_W'(holder_index_next) : '0;
    result_beat[M_CHANGED_B]               = changed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      holder_valid   <= 1'b0;
      holder_index   <= '0;
      search_pointer <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (advance) begin
        holder_valid   <= holder_valid_next;
        holder_index   <= holder_index_next;
        search_pointer <= search_pointer_next;
      end
      if (out_ready) begin
        m_tvalid <= in_valid;
      end
    end
    if (advance) begin
      m_tdata <= result_beat;
    end
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for round_robin_lock_arbiter_top: lock, release, rotating search and clear.
// Depends on rrla_pkg and the arbiter RTL; nothing else is read.

module tb;

  import rrla_pkg::*;

  localparam int LINES = NUM_LINES_DEF;

  typedef struct {
    bit           valid;
    bit [GRANT_W-1:0] index;
    bit           changed;
  } grant_t;

  // Tracks holder and search pointer and queues the grant each request beat should produce.
  class grant_scoreboard;
    bit               holder_valid;
    bit [GRANT_W-1:0] holder_index;
    bit [GRANT_W-1:0] search_ptr;
    grant_t           grant_q[$];
    int               errors;

    function new();
      holder_valid = 1'b0;
      holder_index = '0;
      search_ptr   = '0;
      errors       = 0;
    endfunction

    function void note_request(bit [REQ_W-1:0] req, bit clr);
      grant_t g;
      int     line;
      g.changed = 1'b0;
      if (clr) begin
        holder_valid = 1'b0;
        holder_index = '0;
        search_ptr   = '0;
        req          = '0;
        g.changed    = 1'b1;
      end
      if (holder_valid && !req[holder_index]) begin
        holder_valid = 1'b0;
        holder_index = '0;
        search_ptr   = GRANT_W'((search_ptr + 1) % LINES);
        g.changed    = 1'b1;
      end
      // With no holder, the first requesting line at or after the pointer wins.
      if (!holder_valid) begin
        for (int k = 0; k < LINES; k++) begin
          line = (search_ptr + k) % LINES;
          if (req[line]) begin
            holder_valid = 1'b1;
            holder_index = GRANT_W'(line);
            search_ptr   = GRANT_W'(line);
            g.changed    = 1'b1;
            break;
          end
        end
      end
      g.valid = holder_valid;
      g.index = holder_valid ? holder_index : '0;
      grant_q.push_back(g);
    endfunction

    function void compare_field(string name, int exp_val, int got_val);
      if (exp_val != got_val) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, got_val);
        errors++;
      end
    endfunction

    function void check_grant(bit [M_TDATA_W-1:0] beat);
      grant_t g;
      if (grant_q.size() == 0) begin
        $display("%0t: grant beat 0x%h arrived with nothing expected", $time, beat);
        errors++;
        return;
      end
      g = grant_q.pop_front();
      compare_field("grant_valid", g.valid, beat[M_GRANT_VALID_B]);
      compare_field("grant_index", g.index, beat[M_GRANT_IDX_LO +: GRANT_W]);
      compare_field("changed", g.changed, beat[M_CHANGED_B]);
    endfunction

    function int pending();
      return grant_q.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  grant_scoreboard sb;
  int              idle_pct = 0;
  int              stall_pct = 0;
  logic [REQ_W-1:0] cur_req = '0;

  round_robin_lock_arbiter_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Inputs are noted before outputs are checked so a same-edge result still finds its entry.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_request(s_tdata[REQ_W-1:0], s_tuser);
      if (m_tvalid && m_tready) sb.check_grant(m_tdata);
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(input logic [REQ_W-1:0] req, input logic clr);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_TDATA_W - REQ_W){1'b0}}, req};
    s_tuser  <= clr;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  initial begin
    int             mode;
    logic           clr;
    logic [REQ_W-1:0] all_ones;
    all_ones = '1;
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: hold, release with regrant, wraparound, and clears.
    send_beat('0, 1'b0);
    send_beat(all_ones, 1'b0);
    send_beat(all_ones, 1'b0);
    send_beat(all_ones & ~30'h1, 1'b0);
    send_beat(30'h1 << 29, 1'b0);
    send_beat(30'h1 << 29, 1'b0);
    send_beat(30'h1, 1'b0);
    send_beat(all_ones, 1'b1);
    send_beat(all_ones, 1'b0);
    send_beat('0, 1'b1);
    send_beat('0, 1'b1);
    send_beat(30'h2AAA_AAAA, 1'b0);
    send_beat(30'h1555_5555, 1'b0);
    send_beat('0, 1'b0);
    send_beat(30'h4, 1'b0);
    send_beat(30'h4, 1'b1);
    send_beat('0, 1'b0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 67; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 67; end
        default: begin idle_pct = 8; stall_pct = 8; end
      endcase
      repeat (225) begin
        mode = $urandom_range(99);
        clr  = 1'b0;
        if (mode < 5) begin
          clr     = 1'b1;
          cur_req = REQ_W'($urandom);
        end else if (mode < 15) begin
          cur_req = REQ_W'($urandom);
        end else if (mode < 25) begin
          cur_req = (mode < 20) ? '0 : (30'h1 << $urandom_range(LINES - 1));
        end else if (mode < 55) begin
          // Drop the current holder so the pointer moves on.
          if (sb.holder_valid) cur_req[sb.holder_index] = 1'b0;
          if ($urandom_range(1)) cur_req[$urandom_range(LINES - 1)] = 1'b1;
        end else begin
          repeat ($urandom_range(2)) cur_req[$urandom_range(LINES - 1)] ^= 1'b1;
        end
        send_beat(cur_req, clr);
      end
    end
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
